// ===== design/gbpv_pkg.sv =====
// shared constants and types for the greedy base polytope vertex block
package gbpv_pkg;
	localparam int MaxLen = 32;
	localparam int IdxW = $clog2(MaxLen);
	localparam int CntW = $clog2(MaxLen + 1);
	localparam int SumW = 16 + CntW;
	localparam int ValW = 48;

	localparam logic [1:0] ModeProd = 2'd0;
	localparam logic [1:0] ModeMin = 2'd1;
	localparam logic [1:0] ModeMinCap = 2'd2;
	localparam logic [1:0] ModeProdCap = 2'd3;

	localparam logic [0:0] RegMode = 1'b0;
	localparam logic [0:0] RegCap = 1'b1;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SORT = 7'b0000010,
		ST_CMP = 7'b0000100,
		ST_CAP1 = 7'b0001000,
		ST_CAP2 = 7'b0010000,
		ST_EMIT = 7'b0100000,
		ST_OUT = 7'b1000000
	} state_t;
endpackage

// ===== design/greedy_base_polytope_vertex.sv =====
// top level of the greedy base polytope vertex block
//
// elements are taken one per request while busy is low; each request is
// stored in the element stores. on the last element (or the 32nd) busy rises
// and the set is sorted by a stable insertion sort that does one key compare
// per cycle on a shared comparator, walking the insertion point down through
// the order store. the caps are then formed in ST_CMP, ST_CAP1 and ST_CAP2 on
// the one shared multiplier (d*T, then d*T*T as a low and a high partial
// product), and the emit phase takes each element through ST_EMIT (gain
// product), then ST_OUT (the difference and saturation), one result on the
// strobe per element, in ascending key order, last_out on the final one.
// results cannot be held off. weight_mode and cap_fraction are read only
// after the set closes; the user must write them over the apb port only
// while the block is idle, which the block itself does not enforce.
module greedy_base_polytope_vertex (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [31:0]   sort_key,
	input  logic [15:0]          elem_weight,
	input  logic signed [40:0]   elem_offset,
	input  logic                 last_elem,
	output logic                 strobe,
	output logic signed [47:0]   vertex_value,
	output logic [4:0]           elem_index,
	output logic                 last_out,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import gbpv_pkg::*;

	// element stores, written only for the current set
	logic signed [31:0] key_mem [MaxLen];
	logic [15:0]        wgt_mem [MaxLen];
	logic signed [40:0] off_mem [MaxLen];
	logic [IdxW-1:0]    ord_mem [MaxLen];

	state_t              state_q;
	logic [CntW-1:0]     count_q;
	logic [CntW-1:0]     len_q;
	logic [CntW-1:0]     i_q;      // element being inserted / emitted
	logic [CntW-1:0]     j_q;      // insertion point
	logic [SumW-1:0]     total_q;
	logic [SumW-1:0]     prefix_q;
	logic [1:0]          mode_q;
	logic [15:0]         cap_q;
	logic [63:0]         prod_q;   // shared multiplier output
	logic [47:0]         capv_q;   // cap value for modes 2 and 3
	logic [47:0]         fprev_q;

	// configuration port
	assign pready = 1'b1;
	logic wr_en;
	assign wr_en = psel && penable && pwrite;
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			RegMode: prdata = {30'd0, mode_q};
			RegCap:  prdata = {16'd0, cap_q};
			default: prdata = '0;
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ModeProd;
			cap_q <= 16'hFFFF;
		end else if (wr_en && paddr[1:0] == 2'b00) begin
			if (paddr[2] == RegMode) mode_q <= pwdata[1:0];
			else cap_q <= pwdata[15:0];
		end
	end

	logic accept;
	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);

	logic close_set;
	assign close_set = last_elem || (count_q == CntW'(MaxLen - 1));

	// sort compare: key at order[j-1] vs key of element i
	logic [IdxW-1:0] jm1;
	logic [IdxW-1:0] prev_e;
	logic            shift_down;
	assign jm1 = IdxW'(j_q - 1'b1);
	assign prev_e = ord_mem[jm1];
	assign shift_down = (j_q != '0) && (key_mem[prev_e] > key_mem[i_q[IdxW-1:0]]);

	// emit arithmetic
	logic [15:0]     w_e;
	logic [SumW-1:0] s_new;
	logic [SumW-1:0] r_new;
	assign w_e = wgt_mem[ord_mem[i_q[IdxW-1:0]]];
	assign s_new = prefix_q + SumW'(w_e);
	assign r_new = total_q - s_new;

	// shared multiplier operand select
	logic [31:0] mul_a, mul_b;
	always_comb begin
		mul_a = 32'(s_new);
		mul_b = 32'(r_new);
		priority case (1'b1)
			state_q[2]: begin
				mul_a = 32'(cap_q);
				mul_b = 32'(total_q);
			end
			state_q[3]: begin
				// low 32 bits of d*T
				mul_a = prod_q[31:0];
				mul_b = 32'(total_q);
			end
			state_q[4]: begin
				// bits 37:32 of d*T, kept in the mode 2 cap
				mul_a = 32'(capv_q[21:16]);
				mul_b = 32'(total_q);
			end
			default: ;
		endcase
	end

	logic [63:0] mul_p;
	assign mul_p = 64'(mul_a) * 64'(mul_b);

	// d*T*T from the low partial product and the high one
	logic [63:0] cap3_full;
	assign cap3_full = prod_q + {mul_p[31:0], 32'd0};

	logic [47:0] f_min, f_next;
	logic        last_k;
	assign last_k = (i_q + 1'b1 == len_q);
	always_comb begin
		f_min = (s_new < r_new) ? 48'(s_new) : 48'(r_new);
		f_next = '0;
		if (!last_k) begin
			unique case (mode_q)
				ModeProd:    f_next = prod_q[47:0];
				ModeMin:     f_next = f_min;
				ModeMinCap:  f_next = (f_min < capv_q) ? f_min : capv_q;
				ModeProdCap: f_next = (prod_q[47:0] < capv_q) ? prod_q[47:0] : capv_q;
				default:     f_next = '0;
			endcase
		end
	end

	logic signed [49:0] diff;
	assign diff = $signed({2'b00, f_next}) - $signed({2'b00, fprev_q})
		- 50'(off_mem[ord_mem[i_q[IdxW-1:0]]]);

	always_ff @(posedge clk) begin
		if (accept) begin
			key_mem[count_q[IdxW-1:0]] <= sort_key;
			wgt_mem[count_q[IdxW-1:0]] <= elem_weight;
			off_mem[count_q[IdxW-1:0]] <= elem_offset;
		end
		if (state_q == ST_SORT) begin
			if (shift_down) ord_mem[j_q[IdxW-1:0]] <= prev_e;
			else ord_mem[j_q[IdxW-1:0]] <= i_q[IdxW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			strobe <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (close_set) begin
							len_q <= count_q + 1'b1;
							count_q <= '0;
							i_q <= '0;
							j_q <= '0;
							state_q <= ST_SORT;
						end else begin
							count_q <= count_q + 1'b1;
						end
						total_q <= (count_q == '0) ? SumW'(elem_weight)
							: total_q + SumW'(elem_weight);
					end
				end
				ST_SORT: begin
					if (shift_down) begin
						j_q <= j_q - 1'b1;
					end else if (i_q + 1'b1 == len_q) begin
						state_q <= ST_CMP;
					end else begin
						i_q <= i_q + 1'b1;
						j_q <= i_q + 1'b1;
					end
				end
				ST_CMP: begin
					// d*T
					prod_q <= mul_p;
					state_q <= ST_CAP1;
				end
				ST_CAP1: begin
					// low part of d*T*T; mode 2 cap taken from d*T
					capv_q <= 48'(prod_q[63:16]);
					prod_q <= mul_p;
					state_q <= ST_CAP2;
				end
				ST_CAP2: begin
					if (mode_q == ModeProdCap) capv_q <= cap3_full[63:16];
					i_q <= '0;
					prefix_q <= '0;
					fprev_q <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					prod_q <= mul_p;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					strobe <= 1'b1;
					elem_index <= 5'(ord_mem[i_q[IdxW-1:0]]);
					last_out <= last_k;
					if (diff > 50'sh7FFFFFFFFFFF) vertex_value <= 48'sh7FFFFFFFFFFF;
					else if (diff < -50'sh800000000000)
						vertex_value <= 48'sh800000000000;
					else vertex_value <= diff[47:0];
					fprev_q <= f_next;
					prefix_q <= s_new;
					i_q <= i_q + 1'b1;
					state_q <= last_k ? ST_IDLE : ST_EMIT;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== verif/tb.sv =====
// testbench for greedy_base_polytope_vertex: directed and random sets checked against a built-in predictor
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gbpv_pkg::*;

	// dut connections
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [31:0] sort_key = '0;
	logic [15:0] elem_weight = '0;
	logic signed [40:0] elem_offset = '0;
	logic last_elem = 1'b0;
	logic strobe;
	logic signed [47:0] vertex_value;
	logic [4:0] elem_index;
	logic last_out;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	greedy_base_polytope_vertex uut (.*);

	always #2 clk = ~clk;

	// one expected vertex entry
	typedef struct packed {
		logic signed [47:0] value;
		logic [4:0] index;
		logic last;
	} vertex_t;

	vertex_t vertex_fifo[$];

	// predictor copy of the block state
	logic [1:0] mode_sh = ModeProd;
	logic [15:0] cap_sh = 16'hFFFF;
	logic signed [31:0] keys_sh[MaxLen];
	logic [15:0] wts_sh[MaxLen];
	logic signed [40:0] offs_sh[MaxLen];
	int held = 0;

	int mismatches = 0;
	int requests = 0;
	int sets_done = 0;
	int results_seen = 0;

	// set function value g for prefix s of total t, k of n
	function automatic logic [63:0] gain_of(int k, int n, logic [63:0] s, logic [63:0] t);
		logic [63:0] r;
		logic [63:0] m;
		logic [63:0] c;
		r = t - s;
		if (k == 0 || k >= n)
			return 64'd0;
		m = (s < r) ? s : r;
		case (mode_sh)
			ModeProd: return s * r;
			ModeMin: return m;
			ModeMinCap: begin
				c = ({48'd0, cap_sh} * t) >> 16;
				return (m < c) ? m : c;
			end
			default: begin
				c = ({48'd0, cap_sh} * t * t) >> 16;
				return (s * r < c) ? s * r : c;
			end
		endcase
	endfunction

	// store one element; on a closing element sort and queue the vertex
	task automatic predict_vertex(logic signed [31:0] k, logic [15:0] w,
			logic signed [40:0] o, logic lst);
		int ord[MaxLen];
		int n;
		int j;
		int cur;
		logic [63:0] total;
		logic [63:0] prefix;
		logic [63:0] fprev;
		logic [63:0] fnext;
		logic signed [63:0] v;
		vertex_t e;
		keys_sh[held] = k;
		wts_sh[held] = w;
		offs_sh[held] = o;
		held++;
		if (!lst && held < MaxLen)
			return;
		n = held;
		held = 0;
		// stable insertion sort, ascending key
		for (int i = 0; i < n; i++) begin
			cur = i;
			j = i;
			while (j > 0 && keys_sh[ord[j-1]] > keys_sh[cur]) begin
				ord[j] = ord[j-1];
				j--;
			end
			ord[j] = cur;
		end
		total = 0;
		for (int i = 0; i < n; i++)
			total += wts_sh[i];
		prefix = 0;
		fprev = 0;
		for (int i = 0; i < n; i++) begin
			prefix += wts_sh[ord[i]];
			fnext = gain_of(i + 1, n, prefix, total);
			v = $signed(fnext) - $signed(fprev) - 64'(offs_sh[ord[i]]);
			if (v > 64'sh7FFF_FFFF_FFFF)
				v = 64'sh7FFF_FFFF_FFFF;
			if (v < -64'sh8000_0000_0000)
				v = -64'sh8000_0000_0000;
			e.value = v[47:0];
			e.index = ord[i][4:0];
			e.last = (i + 1 == n);
			vertex_fifo.push_back(e);
			fprev = fnext;
		end
		sets_done++;
	endtask

	// checker: each strobed result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			results_seen++;
			if (vertex_fifo.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result value=%0d index=%0d last=%0b",
						vertex_value, elem_index, last_out);
			end else begin
				vertex_t x;
				x = vertex_fifo.pop_front();
				if (x.value !== vertex_value || x.index !== elem_index
						|| x.last !== last_out) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp value=%0d index=%0d last=%0b, got value=%0d index=%0d last=%0b",
							x.value, x.index, x.last, vertex_value, elem_index, last_out);
				end
			end
		end
	end

	// send one request, random gap first; returns at the accepting edge
	task automatic send_elem(logic signed [31:0] k, logic [15:0] w,
			logic signed [40:0] o, logic lst);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		sort_key = k;
		elem_weight = w;
		elem_offset = o;
		last_elem = lst;
		// busy only moves at rising edges, so it is stable here
		while (busy)
			@(negedge clk);
		@(posedge clk);
		requests++;
		predict_vertex(k, w, o, lst);
	endtask

	// hold off until all queued results are out and the block is quiet
	task automatic wait_drain();
		@(negedge clk);
		start = 1'b0;
		while (vertex_fifo.size() != 0 || busy)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// register write over apb, block must be idle
	task automatic reg_write(logic [0:0] idx, logic [31:0] val);
		wait_drain();
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == RegMode)
			mode_sh = val[1:0];
		else
			cap_sh = val[15:0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	function automatic logic signed [40:0] rand_offset();
		return 41'({$urandom, $urandom} >> 23);
	endfunction

	// one set of n elements; narrow keys make ties likely
	task automatic send_set(int n, bit narrow, bit flag_last);
		logic signed [31:0] k;
		logic [15:0] w;
		for (int i = 0; i < n; i++) begin
			k = narrow ? 32'($signed($urandom_range(0, 6)) - 3) : $urandom;
			w = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
			send_elem(k, w, rand_offset(), flag_last && (i == n - 1));
		end
	endtask

	task automatic test_directed();
		// single element: result is minus the offset
		send_elem(32'sh7FFF_FFFF, 16'hFFFF, 41'sh0_FFFF_FFFF_FF, 1'b1);
		send_elem(-32'sh8000_0000, 16'h0000, -41'sh100_0000_0000, 1'b1);
		// extremes of keys, ties and weights in one set
		send_elem(32'sh7FFF_FFFF, 16'hFFFF, 41'sh0FF_FFFF_FFFF, 1'b0);
		send_elem(-32'sh8000_0000, 16'hFFFF, -41'sh100_0000_0000, 1'b0);
		send_elem(32'sd0, 16'h0000, 41'sd0, 1'b0);
		send_elem(32'sd0, 16'h8000, -41'sd1, 1'b0);
		send_elem(-32'sh8000_0000, 16'h0001, 41'sd5, 1'b1);
		// full store closes the set without a last flag
		send_set(MaxLen, 1'b1, 1'b0);
	endtask

	task automatic test_modes();
		logic [15:0] caps[4];
		caps = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0000};
		caps[3] = 16'($urandom);
		for (int m = 0; m < 4; m++) begin
			reg_write(RegMode, 32'(m));
			for (int c = 0; c < 4; c++) begin
				reg_write(RegCap, {16'h0, caps[c]});
				send_set($urandom_range(2, 6), 1'b0, 1'b1);
			end
			send_set(MaxLen, 1'b0, 1'b1);
		end
	endtask

	task automatic test_random();
		int target;
		target = requests + 230;
		while (requests < target) begin
			if ($urandom_range(0, 9) == 0) begin
				reg_write(RegMode, $urandom);
				reg_write(RegCap, $urandom);
			end
			case ($urandom_range(0, 9))
				0: send_set(MaxLen, $urandom_range(0, 1), 1'b0);
				1: send_set(1, 1'b0, 1'b1);
				2, 3: send_set($urandom_range(2, 32), $urandom_range(0, 1), 1'b1);
				default: send_set($urandom_range(2, 8), $urandom_range(0, 1), 1'b1);
			endcase
			// pause until drained now and then
			if ($urandom_range(0, 15) == 0)
				wait_drain();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		wait_drain();
		test_modes();
		test_random();
		wait_drain();
		repeat (50) @(posedge clk);
		$display("covered %0d requests in %0d sets, %0d results checked",
			requests, sets_done, results_seen);
		$display("all four modes, cap extremes, ties, full-store sets, single elements");
		if (mismatches == 0 && vertex_fifo.size() == 0) begin
			$display("tb: clean");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, vertex_fifo.size());
			$display("tb: errors");
		end
		$finish;
	end

	// watchdog
	initial begin
		#8ms;
		$display("timeout");
		$display("tb: errors");
		$finish;
	end
endmodule
